/* hdl/piecewise_linear_interp_table_top_defines.svh */
// Assertion macros used by the port-level checker file.
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PLT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PLT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/plit_pkg.sv */
// Package: shared constants and operation codes for the interpolation table.
package plit_pkg;
  localparam int MAX_ANCHORS_DEF = 32;
  localparam logic signed [31:0] EMPTY_VALUE = 32'sd1000;
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;
  // divider control between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;
endpackage

/* hdl/plit_div.sv */
// Divider: restoring signed 64 by 17 bit division, one quotient bit a cycle.
module plit_div (
  input  logic                clk,
  input  logic                rst_n,
  input  plit_pkg::div_ctl_t  ctl,
  input  logic signed [63:0]  dividend,
  input  logic        [16:0]  divisor,
  output logic signed [63:0]  quotient,
  output logic                done
);
  logic [63:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] dsr_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [17:0] trial;
  logic [63:0] mag;

  assign mag = dividend[63] ? (~dividend + 64'd1) : dividend;

  always_comb begin
    trial   = {rem_r[16:0], q_r[63]};
    q_nxt   = {q_r[62:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt  = trial - {1'b0, dsr_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        q_r    <= mag;
        rem_r  <= '0;
        dsr_r  <= divisor;
        neg_r  <= dividend[63];
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg_r ? (~q_r + 64'd1) : q_r;
endmodule

/* hdl/piecewise_linear_interp_table_top.sv */
// Top level: sorted anchor tables, sequencer and interpolation datapath.
//
//  Channel | Ports                                   | Direction
//  input   | start, busy, in_op/curve/key/anchor_value | in (busy out)
//  result  | out_valid, out_scaler, out_status        | out
//
// Clear and the unused op go straight to done. Insert and lookup scan each anchor
// by check, registered read and compare; insert of a new key then moves entries
// up with a read and a write each, plus write and done. Lookup between anchors
// adds multiply, divider start, divider wait and done.
// Synchronous active-low reset empties both tables; memories are not cleared.
// The result strobe follows the last busy cycle, lasts one cycle, cannot stall.
module piecewise_linear_interp_table_top #(
  parameter int MAX_ANCHORS = plit_pkg::MAX_ANCHORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic               in_curve,
  input  logic [15:0]        in_key,
  input  logic signed [31:0] in_anchor_value,
  output logic               out_valid,
  output logic signed [31:0] out_scaler,
  output logic               out_status
);
  localparam int IW = $clog2(MAX_ANCHORS);
  localparam int CW = $clog2(MAX_ANCHORS + 1);
  localparam int AW = IW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_SHRD, S_SHWR, S_WR, S_LRD, S_MUL, S_DVS, S_DIV, S_DONE
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      cnt_r [2];
  logic               cur_r;
  logic [1:0]         op_r;
  logic [15:0]        key_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      i_r;
  logic [CW-1:0]      j_r;
  logic [15:0]        mk [2**AW];
  logic signed [31:0] mv [2**AW];
  logic [15:0]        rk_r;
  logic signed [31:0] rv_r;
  logic [15:0]        klo_r;
  logic signed [31:0] vlo_r;
  logic signed [32:0] diff_r;
  logic [16:0]        span_r;
  logic [16:0]        off_r;
  logic signed [50:0] mul_w;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic               stat_r;
  logic               rd_en;
  logic [AW-1:0]      rd_a;
  logic               wr_en;
  logic [AW-1:0]      wr_a;
  logic [15:0]        wr_k;
  logic signed [31:0] wr_v;
  plit_pkg::div_ctl_t dctl;
  logic signed [63:0] quo;
  logic               ddone;
  logic [CW-1:0]      n;

  assign n = cnt_r[cur_r];

  // 33 x 18 signed product; value difference times offset from lower key
  assign mul_w = diff_r * $signed({1'b0, off_r});

  // memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mk[wr_a] <= wr_k;
      mv[wr_a] <= wr_v;
    end
    if (rd_en) begin
      rk_r <= mk[rd_a];
      rv_r <= mv[rd_a];
    end
  end

  plit_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(prod_r),
    .divisor(span_r), .quotient(quo), .done(ddone)
  );

  // memory port selection and divider start
  always_comb begin
    rd_en = 1'b0;
    rd_a  = {cur_r, i_r[IW-1:0]};
    wr_en = 1'b0;
    wr_a  = {cur_r, i_r[IW-1:0]};
    wr_k  = key_r;
    wr_v  = val_r;
    dctl.start = (state_r == S_DVS);
    case (state_r)
      S_RD:   rd_en = 1'b1;
      S_SHRD: begin
        rd_en = 1'b1;
        rd_a  = {cur_r, IW'(j_r - CW'(1))};
      end
      S_SHWR: begin
        wr_en = 1'b1;
        wr_a  = {cur_r, j_r[IW-1:0]};
        wr_k  = rk_r;
        wr_v  = rv_r;
      end
      S_WR:   wr_en = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r[0]  <= '0;
      cnt_r[1]  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          op_r   <= in_op;
          cur_r  <= in_curve;
          key_r  <= in_key;
          val_r  <= in_anchor_value;
          i_r    <= '0;
          res_r  <= '0;
          stat_r <= 1'b0;
          case (in_op)
            plit_pkg::OP_CLEAR: begin
              cnt_r[0] <= '0;
              cnt_r[1] <= '0;
              state_r  <= S_DONE;
            end
            plit_pkg::OP_INSERT, plit_pkg::OP_LOOKUP: state_r <= S_CHK;
            default: state_r <= S_DONE;
          endcase
        end
        // i_r < n: read entry; otherwise scan ended
        S_CHK: begin
          if (i_r < n) state_r <= S_RD;
          else if (op_r == plit_pkg::OP_INSERT) begin
            if (n >= CW'(MAX_ANCHORS)) begin
              stat_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              j_r     <= n;
              state_r <= (n > i_r) ? S_SHRD : S_WR;
            end
          end else begin
            // past last key, or empty table
            res_r   <= (n == '0) ? plit_pkg::EMPTY_VALUE : vlo_r;
            state_r <= S_DONE;
          end
        end
        S_RD: state_r <= S_LRD;
        S_LRD: begin
          if (rk_r < key_r) begin
            klo_r   <= rk_r;
            vlo_r   <= rv_r;
            i_r     <= i_r + CW'(1);
            state_r <= S_CHK;
          end else if (op_r == plit_pkg::OP_INSERT) begin
            if (rk_r == key_r) state_r <= S_WR;
            else if (n >= CW'(MAX_ANCHORS)) begin
              stat_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              j_r     <= n;
              state_r <= S_SHRD;
            end
          end else if (i_r == '0) begin
            res_r   <= rv_r;
            state_r <= S_DONE;
          end else begin
            diff_r  <= 33'(rv_r) - 33'(vlo_r);
            span_r  <= {1'b0, rk_r} - {1'b0, klo_r};
            off_r   <= {1'b0, key_r} - {1'b0, klo_r};
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= 64'(mul_w);
          state_r <= S_DVS;
        end
        // divider latches the registered product here
        S_DVS: state_r <= S_DIV;
        S_DIV: if (ddone) begin
          res_r   <= 32'(64'(vlo_r) + quo);
          state_r <= S_DONE;
        end
        S_SHRD: state_r <= S_SHWR;
        S_SHWR: begin
          j_r     <= j_r - CW'(1);
          state_r <= (j_r - CW'(1) > i_r) ? S_SHRD : S_WR;
        end
        S_WR: begin
          if (!(i_r < n && rk_r == key_r)) cnt_r[cur_r] <= n + CW'(1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_scaler = res_r;
  assign out_status = stat_r;
endmodule

/* hdl/plit_checker.sv */
// Checker: port-level properties of the interpolation table, bound to top.
`include "piecewise_linear_interp_table_top_defines.svh"
module plit_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_scaler,
  input logic               out_status
);
  `PLT_ASSERT_NXT(a_acc_busy, clk, rst_n, start && !busy, busy, "accept not busy")
  `PLT_ASSERT_IMP(a_val_busy, clk, rst_n, out_valid, !busy, "result while busy")
  `PLT_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid, "double strobe")
  `PLT_ASSERT_IMP(a_stat_scl, clk, rst_n, out_valid && out_status, out_scaler == '0, "stat val")
endmodule

bind piecewise_linear_interp_table_top plit_checker u_plit_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_scaler(out_scaler), .out_status(out_status)
);

/* tb/interp_table_checker.sv */
// Checker: predicts every result word of the interpolation table and compares it.
module interp_table_checker #(
  parameter int MAX_ANCHORS = plit_pkg::MAX_ANCHORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_op,
  input  logic               in_curve,
  input  logic [15:0]        in_key,
  input  logic signed [31:0] in_anchor_value,
  input  logic               out_valid,
  input  logic signed [31:0] out_scaler,
  input  logic               out_status,
  output int                 fail_count,
  output int                 pending
);
  typedef struct packed {
    logic signed [31:0] scaler;
    logic               status;
  } result_t;

  logic [15:0]        curve_keys[2][MAX_ANCHORS];
  logic signed [31:0] curve_vals[2][MAX_ANCHORS];
  int                 curve_len[2];
  result_t            expected_q[$];

  function automatic logic signed [31:0] interp_point(int c, logic [15:0] p);
    int i;
    longint lo, hi, klo, khi;
    i = 0;
    if (curve_len[c] == 0) return plit_pkg::EMPTY_VALUE;
    while (i < curve_len[c] && curve_keys[c][i] < p) i++;
    if (i == curve_len[c]) return curve_vals[c][i-1];
    if (i == 0) return curve_vals[c][0];
    lo = curve_vals[c][i-1];
    hi = curve_vals[c][i];
    klo = curve_keys[c][i-1];
    khi = curve_keys[c][i];
    // SV division truncates toward zero, as required
    return 32'(lo + ((hi - lo) * (longint'(p) - klo)) / (khi - klo));
  endfunction

  function automatic logic add_anchor(int c, logic [15:0] k, logic signed [31:0] v);
    int i;
    i = 0;
    while (i < curve_len[c] && curve_keys[c][i] < k) i++;
    if (i < curve_len[c] && curve_keys[c][i] == k) begin
      curve_vals[c][i] = v;
      return 1'b0;
    end
    if (curve_len[c] >= MAX_ANCHORS) return 1'b1;
    for (int j = curve_len[c]; j > i; j--) begin
      curve_keys[c][j] = curve_keys[c][j-1];
      curve_vals[c][j] = curve_vals[c][j-1];
    end
    curve_keys[c][i] = k;
    curve_vals[c][i] = v;
    curve_len[c]++;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    result_t r, got;
    if (!rst_n) begin
      curve_len[0] = 0;
      curve_len[1] = 0;
      expected_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // result checked before the new word so same-edge order is irrelevant
      if (out_valid) begin
        got = '{out_scaler, out_status};
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: actual scaler=%0d status=%0b",
                   $time, out_scaler, out_status);
          fail_count <= fail_count + 1;
        end else begin
          r = expected_q.pop_front();
          if (got !== r) begin
            $display("%0t mismatch: expected scaler=%0d status=%0b actual scaler=%0d status=%0b",
                     $time, r.scaler, r.status, out_scaler, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        r = '0;
        case (plit_pkg::op_t'(in_op))
          plit_pkg::OP_CLEAR: begin
            curve_len[0] = 0;
            curve_len[1] = 0;
          end
          plit_pkg::OP_INSERT: r.status = add_anchor(in_curve, in_key, in_anchor_value);
          plit_pkg::OP_LOOKUP: r.scaler = interp_point(in_curve, in_key);
          default: ;
        endcase
        expected_q.push_back(r);
      end
      pending <= expected_q.size();
    end
  end
endmodule

/* tb/tb.sv */
// Testbench top: drives command words into the interpolation table and gives the verdict.
module tb;
  localparam int WATCHDOG_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic               in_curve;
  logic [15:0]        in_key;
  logic signed [31:0] in_anchor_value;
  logic               out_valid;
  logic signed [31:0] out_scaler;
  logic               out_status;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;

  piecewise_linear_interp_table_top dut (.*);

  interp_table_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: cycles with neither an accepted word nor a result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one word: drop start for the gap, if any, then hold start until the
  // block takes the word. Start stays high for a word that follows at once.
  task automatic send_word(plit_pkg::op_t op, logic c, logic [15:0] k,
                           logic signed [31:0] v);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;  // back-to-back stretches
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_curve <= c;
    in_key <= k;
    in_anchor_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Keys half the time from a narrow window so replacements and brackets happen.
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 3)) ? 16'hFFFF - 16'($urandom_range(0, 3)) : 16'd0;
      default: return 16'($urandom_range(100, 400));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom);
      default: return 32'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  initial begin
    int rounds;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = plit_pkg::OP_CLEAR;
    in_curve = 1'b0;
    in_key = '0;
    in_anchor_value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty lookups, ends, clamps, full-scale slopes, full table.
    send_word(plit_pkg::OP_LOOKUP, 1'b0, 16'd5, 32'sd0);
    send_word(plit_pkg::OP_LOOKUP, 1'b1, 16'hFFFF, 32'sd0);
    send_word(plit_pkg::OP_INSERT, 1'b0, 16'd0, 32'sh80000000);
    send_word(plit_pkg::OP_INSERT, 1'b0, 16'hFFFF, 32'sh7FFFFFFF);
    send_word(plit_pkg::OP_LOOKUP, 1'b0, 16'd0, 32'sd0);
    send_word(plit_pkg::OP_LOOKUP, 1'b0, 16'h7FFF, 32'sd0);
    send_word(plit_pkg::OP_LOOKUP, 1'b0, 16'hFFFF, 32'sd0);
    send_word(plit_pkg::OP_INSERT, 1'b1, 16'd100, 32'sd500);
    send_word(plit_pkg::OP_LOOKUP, 1'b1, 16'd3, 32'sd0);
    send_word(plit_pkg::OP_LOOKUP, 1'b1, 16'd900, 32'sd0);
    send_word(plit_pkg::OP_INSERT, 1'b1, 16'd200, -32'sd501);
    send_word(plit_pkg::OP_LOOKUP, 1'b1, 16'd133, 32'sd0);
    send_word(plit_pkg::OP_INSERT, 1'b1, 16'd100, 32'sd7);
    send_word(plit_pkg::OP_LOOKUP, 1'b1, 16'd150, 32'sd0);
    send_word(plit_pkg::OP_NONE, 1'b1, 16'hFFFF, 32'shFFFFFFFF);
    for (int i = 0; i < plit_pkg::MAX_ANCHORS_DEF; i++)
      send_word(plit_pkg::OP_INSERT, 1'b1, 16'(300 + i * 3), 32'(i * 37));
    send_word(plit_pkg::OP_INSERT, 1'b1, 16'd1, 32'sd1);  // table full: rejected
    send_word(plit_pkg::OP_INSERT, 1'b1, 16'd303, 32'sd9); // replace while full
    send_word(plit_pkg::OP_LOOKUP, 1'b1, 16'd304, 32'sd0);
    send_word(plit_pkg::OP_CLEAR, 1'b0, 16'd0, 32'sd0);
    send_word(plit_pkg::OP_LOOKUP, 1'b1, 16'd304, 32'sd0);
    start <= 1'b0;

    // Let everything drain once before random traffic.
    wait (pending == 0);
    @(posedge clk);

    // Random: mostly inserts and lookups, clears rare so tables fill up.
    rounds = 0;
    while (rounds < 2000) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 2)
        send_word(plit_pkg::OP_CLEAR, 1'($urandom), pick_key(), pick_value());
      else if (sel < 4)
        send_word(plit_pkg::OP_NONE, 1'($urandom), pick_key(), pick_value());
      else if (sel < 45)
        send_word(plit_pkg::OP_INSERT, 1'($urandom), pick_key(), pick_value());
      else
        send_word(plit_pkg::OP_LOOKUP, 1'($urandom), pick_key(), pick_value());
      rounds++;
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
